// File: sv/rgb_to_nv12_converter_defines.svh
// Assertion macros, clocked on clk; rst disables the checked form.
`ifndef RGB_TO_NV12_CONVERTER_DEFINES_SVH
`define RGB_TO_NV12_CONVERTER_DEFINES_SVH

`ifndef SYNTH
`define R2N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define R2N_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define R2N_ASSERT(lbl, prop, msg)
`define R2N_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: sv/r2n_pkg.sv
`timescale 1ns / 1ps

package r2n_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SUM_W      = 18;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(1920);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(1080);
  localparam logic [CFG_DATA_W-1:0] WIDTH_MAX    = CFG_DATA_W'(MAX_WIDTH);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX   = CFG_DATA_W'(MAX_HEIGHT);

  localparam logic signed [SUM_W-1:0] COEF_Y_R  = 18'sd66;
  localparam logic signed [SUM_W-1:0] COEF_Y_G  = 18'sd129;
  localparam logic signed [SUM_W-1:0] COEF_Y_B  = 18'sd25;
  localparam logic signed [SUM_W-1:0] COEF_CB_R = -18'sd38;
  localparam logic signed [SUM_W-1:0] COEF_CB_G = -18'sd74;
  localparam logic signed [SUM_W-1:0] COEF_CB_B = 18'sd112;
  localparam logic signed [SUM_W-1:0] COEF_CR_R = 18'sd112;
  localparam logic signed [SUM_W-1:0] COEF_CR_G = -18'sd94;
  localparam logic signed [SUM_W-1:0] COEF_CR_B = -18'sd18;
  localparam logic signed [SUM_W-1:0] ROUND     = 18'sd128;
  localparam logic [PIX_W-1:0]        LUMA_BIAS   = 8'd16;
  localparam logic [PIX_W-1:0]        CHROMA_BIAS = 8'd128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } pos_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
  } ycc_t;

endpackage

// File: sv/r2n_if.sv
`timescale 1ns / 1ps

interface r2n_pixel_if
  import r2n_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

interface r2n_ycc_if
  import r2n_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic             chroma_valid;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] chroma_red;
  logic             frame_end;

  modport source (output valid, luma, chroma_valid, chroma_blue, chroma_red, frame_end,
                  input ready);
  modport sink   (input valid, luma, chroma_valid, chroma_blue, chroma_red, frame_end,
                  output ready);
endinterface

interface r2n_cfg_if
  import r2n_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/r2n_pos.sv
`timescale 1ns / 1ps

module r2n_pos
  import r2n_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [CFG_DATA_W-1:0] image_width,
  input  logic [CFG_DATA_W-1:0] image_height,
  output pos_flags_t            flags
);

  logic [COL_W-1:0]      column_count;
  logic [ROW_W-1:0]      row_count;
  logic [COL_W-1:0]      column_count_next;
  logic [ROW_W-1:0]      row_count_next;
  logic [CFG_DATA_W-1:0] width_eff;
  logic [CFG_DATA_W-1:0] height_eff;
  logic                  last_col;
  logic                  last_row;

  always_comb begin
    width_eff  = (image_width == '0 || image_width > WIDTH_MAX) ? WIDTH_MAX : image_width;
    height_eff = (image_height == '0 || image_height > HEIGHT_MAX) ? HEIGHT_MAX : image_height;
    last_col   = CFG_DATA_W'(column_count) >= (width_eff - CFG_DATA_W'(1));
    last_row   = CFG_DATA_W'(row_count) >= (height_eff - CFG_DATA_W'(1));

    flags.chroma_valid = !column_count[0] && !row_count[0];
    flags.frame_end    = last_col && last_row;

    column_count_next = column_count;
    row_count_next    = row_count;
    if (advance) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next    = last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count_next = column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: sv/r2n_csc.sv
`timescale 1ns / 1ps

module r2n_csc
  import r2n_pkg::*;
(
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  input  logic             chroma_en,
  output ycc_t             ycc
);

  logic signed [SUM_W-1:0] bs;
  logic signed [SUM_W-1:0] gs;
  logic signed [SUM_W-1:0] rs;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] cb_sum;
  logic signed [SUM_W-1:0] cr_sum;

  always_comb begin
    bs = signed'({{(SUM_W-PIX_W){1'b0}}, blue});
    gs = signed'({{(SUM_W-PIX_W){1'b0}}, green});
    rs = signed'({{(SUM_W-PIX_W){1'b0}}, red});

    y_sum  = COEF_Y_R * rs + COEF_Y_G * gs + COEF_Y_B * bs + ROUND;
    cb_sum = COEF_CB_R * rs + COEF_CB_G * gs + COEF_CB_B * bs + ROUND;
    cr_sum = COEF_CR_R * rs + COEF_CR_G * gs + COEF_CR_B * bs + ROUND;

    // bits [15:8] are floor(sum / 256) modulo 256
    ycc.luma        = y_sum[15:8] + LUMA_BIAS;
    ycc.chroma_blue = chroma_en ? cb_sum[15:8] + CHROMA_BIAS : '0;
    ycc.chroma_red  = chroma_en ? cr_sum[15:8] + CHROMA_BIAS : '0;
  end

endmodule

// File: sv/rgb_to_nv12_converter.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                                         Transfer
// pixel     in         blue, green, red (8b each)                      valid & ready
// result    out        luma, chroma_valid, chroma_blue, chroma_red,    valid & ready
//                      frame_end
// cfg       in         index (0 width, 1 height), data (13b)           valid & ready
//
// Two register stages: input register, then result register. One pixel per cycle
// sustained while result is not stalled. cfg is always ready.
// Reset (rst, synchronous) empties both stages, zeroes the position counters and
// loads width 1920, height 1080.
// A stall on result backs up stage by stage; pixel.ready drops only when both
// stages hold a pixel.

`include "rgb_to_nv12_converter_defines.svh"

module rgb_to_nv12_converter
  import r2n_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  r2n_pixel_if.sink  pixel,
  r2n_ycc_if.source  result,
  r2n_cfg_if.sink    cfg
);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_blue;
  logic [PIX_W-1:0] s1_green;
  logic [PIX_W-1:0] s1_red;
  pos_flags_t       s1_flags;

  logic             s2_valid;
  ycc_t             s2_ycc;
  pos_flags_t       s2_flags;

  logic             s1_ready;
  logic             s2_ready;
  logic             take_in;
  logic             take_s1;
  pos_flags_t       pos_flags;
  ycc_t             ycc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign s2_ready    = !s2_valid || result.ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign pixel.ready = s1_ready;
  assign take_in     = pixel.valid && s1_ready;
  assign take_s1     = s1_valid && s2_ready;

  r2n_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (take_in),
    .image_width  (image_width),
    .image_height (image_height),
    .flags        (pos_flags)
  );

  r2n_csc u_csc (
    .blue      (s1_blue),
    .green     (s1_green),
    .red       (s1_red),
    .chroma_en (s1_flags.chroma_valid),
    .ycc       (ycc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= pixel.valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_blue  <= pixel.blue;
      s1_green <= pixel.green;
      s1_red   <= pixel.red;
      s1_flags <= pos_flags;
    end
    if (take_s1) begin
      s2_ycc   <= ycc;
      s2_flags <= s1_flags;
    end
  end

  assign result.valid        = s2_valid;
  assign result.luma         = s2_ycc.luma;
  assign result.chroma_valid = s2_flags.chroma_valid;
  assign result.chroma_blue  = s2_ycc.chroma_blue;
  assign result.chroma_red   = s2_ycc.chroma_red;
  assign result.frame_end    = s2_flags.frame_end;

  `R2N_ASSERT(a_no_chroma_zero, result.valid && !result.chroma_valid |-> result.chroma_blue == 8'd0 && result.chroma_red == 8'd0, "chroma not zero on a pixel without chroma")
  `R2N_ASSERT(a_luma_range, result.valid |-> result.luma >= 8'd16 && result.luma <= 8'd235, "luma out of studio range")
  `R2N_ASSERT(a_s1_hold, s1_valid && !s2_ready |=> s1_valid && $stable(s1_blue) && $stable(s1_flags), "input stage lost a pixel under stall")
  `R2N_ASSERT_RST(a_reset_empty, rst |=> !result.valid && !s1_valid, "pipeline not empty after reset")

endmodule
